/* rtl/core/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the CRC frame decoder
// Frame layout constants, status codes, the result record passed from the
// frame engine to the top level, and the CRC16-Modbus byte update.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // frame layout
    localparam int unsigned COUNT_W    = 17;
    localparam logic [COUNT_W-1:0] HDR_LEN        = 17'd7;
    localparam logic [COUNT_W-1:0] CRC_START      = 17'd2;
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd11;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;

    // byte positions of the header fields
    localparam logic [COUNT_W-1:0] POS_PRE0    = 17'd0;
    localparam logic [COUNT_W-1:0] POS_PRE1    = 17'd1;
    localparam logic [COUNT_W-1:0] POS_ID_LO   = 17'd2;
    localparam logic [COUNT_W-1:0] POS_ID_HI   = 17'd3;
    localparam logic [COUNT_W-1:0] POS_TYPE    = 17'd4;
    localparam logic [COUNT_W-1:0] POS_LEN_LO  = 17'd5;
    localparam logic [COUNT_W-1:0] POS_LEN_HI  = 17'd6;

    // marker bytes
    localparam logic [7:0] PRE0 = 8'hAA;
    localparam logic [7:0] PRE1 = 8'h55;
    localparam logic [7:0] TRL0 = 8'h0D;
    localparam logic [7:0] TRL1 = 8'h0A;

    // crc16-modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // reset value of the payload limit
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_SHORT   = 3'd1,
        STATUS_FRAMING = 3'd2,
        STATUS_SIZE    = 3'd3,
        STATUS_CRC     = 3'd4
    } status_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_ident;
        logic [7:0]  frame_kind_code;
        logic [15:0] length_field;
        status_t     status;
    } result_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/cfd_frame_engine.sv */
// ----------------------------------------------------------------------------
// cfd_frame_engine: per-byte frame state and result logic
// Holds the frame position, header fields, running CRC and received CRC.
// One byte is consumed per step; a payload byte or the final byte yields a
// result record, and the final byte returns the frame state to its start.
// ----------------------------------------------------------------------------
module cfd_frame_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic [7:0]      rx_byte,
    input  logic            end_of_frame,
    input  logic [15:0]     max_payload,
    output cfd_pkg::result_t result
);

    logic [cfd_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0] crc_running_reg, crc_running_next;
    logic [15:0] ident_reg, ident_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] declared_len_reg, declared_len_next;
    logic        preamble_bad_reg, preamble_bad_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [7:0]  previous_byte_reg;

    logic [cfd_pkg::COUNT_W-1:0] pos;
    logic [cfd_pkg::COUNT_W-1:0] pay_end;
    logic [cfd_pkg::COUNT_W-1:0] crc_end;
    logic [cfd_pkg::COUNT_W-1:0] frame_total;
    logic        is_payload;
    cfd_pkg::status_t status;

    // header capture, crc and position update
    always_comb begin
        pos               = byte_count_reg;
        ident_next        = ident_reg;
        kind_next         = kind_reg;
        declared_len_next = declared_len_reg;
        preamble_bad_next = preamble_bad_reg;
        received_crc_next = received_crc_reg;
        crc_running_next  = crc_running_reg;
        is_payload        = 1'b0;

        if (pos == cfd_pkg::POS_PRE0 && rx_byte != cfd_pkg::PRE0) preamble_bad_next = 1'b1;
        if (pos == cfd_pkg::POS_PRE1 && rx_byte != cfd_pkg::PRE1) preamble_bad_next = 1'b1;
        if (pos == cfd_pkg::POS_ID_LO)  ident_next[7:0]         = rx_byte;
        if (pos == cfd_pkg::POS_ID_HI)  ident_next[15:8]        = rx_byte;
        if (pos == cfd_pkg::POS_TYPE)   kind_next               = rx_byte;
        if (pos == cfd_pkg::POS_LEN_LO) declared_len_next[7:0]  = rx_byte;
        if (pos == cfd_pkg::POS_LEN_HI) declared_len_next[15:8] = rx_byte;

        pay_end = cfd_pkg::HDR_LEN + {1'b0, declared_len_reg};
        if (pos >= cfd_pkg::HDR_LEN) begin
            if (pos < pay_end) begin
                is_payload = 1'b1;
            end else if (pos == pay_end) begin
                received_crc_next[7:0] = rx_byte;
            end else if (pos == pay_end + 17'd1) begin
                received_crc_next[15:8] = rx_byte;
            end
        end

        // crc covers id through the end of the payload
        crc_end = cfd_pkg::HDR_LEN + {1'b0, declared_len_next};
        if (pos >= cfd_pkg::CRC_START && pos < crc_end) begin
            crc_running_next = cfd_pkg::crc16_byte(crc_running_reg, rx_byte);
        end

        // saturating byte count
        byte_count_next = (byte_count_reg != cfd_pkg::COUNT_MAX) ?
                          byte_count_reg + 17'd1 : byte_count_reg;
    end

    // frame verdict, first failing check decides
    always_comb begin
        frame_total = byte_count_next;
        if (frame_total < cfd_pkg::FRAME_OVERHEAD) begin
            status = cfd_pkg::STATUS_SHORT;
        end else if (preamble_bad_next) begin
            status = cfd_pkg::STATUS_FRAMING;
        end else if (declared_len_next > max_payload ||
                     frame_total != cfd_pkg::FRAME_OVERHEAD + {1'b0, declared_len_next}) begin
            status = cfd_pkg::STATUS_SIZE;
        end else if (previous_byte_reg != cfd_pkg::TRL0 || rx_byte != cfd_pkg::TRL1) begin
            status = cfd_pkg::STATUS_FRAMING;
        end else if (received_crc_next != crc_running_next) begin
            status = cfd_pkg::STATUS_CRC;
        end else begin
            status = cfd_pkg::STATUS_OK;
        end
    end

    // result record
    always_comb begin
        result.valid           = end_of_frame || is_payload;
        result.frame_ident     = ident_next;
        result.frame_kind_code = kind_next;
        result.length_field    = declared_len_next;
        if (end_of_frame) begin
            result.kind       = cfd_pkg::KIND_STATUS;
            result.data_byte  = 8'h00;
            result.byte_index = 16'h0000;
            result.status     = status;
        end else begin
            result.kind       = cfd_pkg::KIND_PAYLOAD;
            result.data_byte  = rx_byte;
            result.byte_index = 16'(pos - cfd_pkg::HDR_LEN);
            result.status     = cfd_pkg::STATUS_OK;
        end
    end

    // frame state, cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && end_of_frame)) begin
            byte_count_reg    <= '0;
            crc_running_reg   <= cfd_pkg::CRC_INIT;
            ident_reg         <= '0;
            kind_reg          <= '0;
            declared_len_reg  <= '0;
            preamble_bad_reg  <= 1'b0;
            received_crc_reg  <= '0;
            previous_byte_reg <= '0;
        end else if (step_en) begin
            byte_count_reg    <= byte_count_next;
            crc_running_reg   <= crc_running_next;
            ident_reg         <= ident_next;
            kind_reg          <= kind_next;
            declared_len_reg  <= declared_len_next;
            preamble_bad_reg  <= preamble_bad_next;
            received_crc_reg  <= received_crc_next;
            previous_byte_reg <= rx_byte;
        end
    end

endmodule

/* rtl/core/crc_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// crc_frame_decoder_top: length-prefixed frame decoder with CRC16-Modbus
// Decodes AA 55 framed packets byte by byte, passes payload bytes on and
// gives a status transaction on the flagged final byte.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake               payload
//  -------   ---   ---------------------   ------------------------------------
//  s_        in    s_valid / s_ready       s_rx_byte, s_end_of_frame
//  m_        out   m_valid / m_ready       m_kind, m_data_byte, m_byte_index,
//                                          m_frame_ident, m_frame_kind_code,
//                                          m_length_field, m_status
//  cfg_      in    cfg_valid / cfg_ready   cfg_max_payload
//
//  One byte per cycle sustained while the output is not stalled: a transaction
//  lands in the input register, goes through the frame engine when the output
//  register has room, and its result is registered in the output register.
//  Reset (aresetn low at a clock edge) empties both registers, restarts the
//  frame and sets max_payload to 256.
//  A stalled output register holds the engine; the input register then
//  fills and s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module crc_frame_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_frame,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_byte_index,
    output logic [15:0] m_frame_ident,
    output logic [7:0]  m_frame_kind_code,
    output logic [15:0] m_length_field,
    output logic [2:0]  m_status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_max_payload
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eof_reg;
    logic        out_valid_reg;
    cfd_pkg::result_t out_reg;
    cfd_pkg::result_t result;
    logic [15:0] max_payload_reg;
    logic        step_en;

    // engine steps when it has a byte and the output register has room
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    // payload limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= cfd_pkg::MAX_PAYLOAD_RST;
        end else if (cfg_valid) begin
            max_payload_reg <= cfg_max_payload;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_eof_reg  <= s_end_of_frame;
        end
    end

    cfd_frame_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .rx_byte      (in_byte_reg),
        .end_of_frame (in_eof_reg),
        .max_payload  (max_payload_reg),
        .result       (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_reg.kind;
    assign m_data_byte       = out_reg.data_byte;
    assign m_byte_index      = out_reg.byte_index;
    assign m_frame_ident     = out_reg.frame_ident;
    assign m_frame_kind_code = out_reg.frame_kind_code;
    assign m_length_field    = out_reg.length_field;
    assign m_status          = out_reg.status;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for crc_frame_decoder_top
// Streams framed packets (clean, damaged and noise) through the decoder under
// several payload limits. A scoreboard class predicts each payload and status
// transaction byte by byte and compares every field of the block's output.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 230;

    typedef logic [7:0] octet_q_t[$];

    typedef struct {
        logic             kind;
        logic [7:0]       data_byte;
        logic [15:0]      byte_index;
        logic [15:0]      frame_ident;
        logic [7:0]       frame_kind_code;
        logic [15:0]      length_field;
        cfd_pkg::status_t status;
    } decoded_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_PREAMBLE,
        FAULT_TRAILER,
        FAULT_CRC_BYTE,
        FAULT_BODY_BIT,
        FAULT_TRUNCATE,
        FAULT_EXTRA,
        FAULT_LENGTH,
        FAULT_NOISE
    } fault_e;

    // scoreboard: running frame decode and the queue of awaited results
    class frame_predictor;
        decoded_t    awaited[$];
        logic [15:0] limit;
        logic [16:0] count;
        logic [15:0] crc;
        logic [15:0] ident;
        logic [15:0] decl_len;
        logic [15:0] rx_crc;
        logic [7:0]  code;
        logic [7:0]  last_byte;
        bit          pre_bad;
        int unsigned errors;
        int unsigned payload_seen;
        int unsigned verdicts[5];

        function new();
            limit = cfd_pkg::MAX_PAYLOAD_RST;
            clear_frame();
        endfunction

        static function logic [15:0] modbus_crc(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ cfd_pkg::CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void clear_frame();
            count     = '0;
            crc       = cfd_pkg::CRC_INIT;
            ident     = '0;
            decl_len  = '0;
            rx_crc    = '0;
            code      = '0;
            last_byte = '0;
            pre_bad   = 1'b0;
        endfunction

        // one accepted input transaction
        function void note_byte(logic [7:0] b, logic eof);
            int unsigned p;
            int unsigned pay_end;
            logic [7:0]  prev;
            bit          is_pay;
            decoded_t    r;
            p       = count;
            pay_end = cfd_pkg::HDR_LEN + decl_len;
            is_pay  = 1'b0;

            // header capture
            if (p == cfd_pkg::POS_PRE0 && b != cfd_pkg::PRE0) pre_bad = 1'b1;
            if (p == cfd_pkg::POS_PRE1 && b != cfd_pkg::PRE1) pre_bad = 1'b1;
            if (p == cfd_pkg::POS_ID_LO)  ident[7:0]     = b;
            if (p == cfd_pkg::POS_ID_HI)  ident[15:8]    = b;
            if (p == cfd_pkg::POS_TYPE)   code           = b;
            if (p == cfd_pkg::POS_LEN_LO) decl_len[7:0]  = b;
            if (p == cfd_pkg::POS_LEN_HI) decl_len[15:8] = b;

            // payload, then the crc bytes just behind it
            if (p >= cfd_pkg::HDR_LEN) begin
                if (p < pay_end) is_pay = 1'b1;
                else if (p == pay_end) rx_crc[7:0] = b;
                else if (p == pay_end + 1) rx_crc[15:8] = b;
            end
            if (p >= cfd_pkg::CRC_START && p < pay_end) crc = modbus_crc(crc, b);

            prev      = last_byte;
            last_byte = b;
            if (count != cfd_pkg::COUNT_MAX) count = count + 1'b1;

            r.kind            = cfd_pkg::KIND_PAYLOAD;
            r.data_byte       = b;
            r.byte_index      = 16'(p - cfd_pkg::HDR_LEN);
            r.frame_ident     = ident;
            r.frame_kind_code = code;
            r.length_field    = decl_len;
            r.status          = cfd_pkg::STATUS_OK;

            // verdict on the flagged byte, first failing check wins
            if (eof) begin
                r.kind       = cfd_pkg::KIND_STATUS;
                r.data_byte  = '0;
                r.byte_index = '0;
                if (count < cfd_pkg::FRAME_OVERHEAD)
                    r.status = cfd_pkg::STATUS_SHORT;
                else if (pre_bad)
                    r.status = cfd_pkg::STATUS_FRAMING;
                else if (decl_len > limit || count != cfd_pkg::FRAME_OVERHEAD + decl_len)
                    r.status = cfd_pkg::STATUS_SIZE;
                else if (prev != cfd_pkg::TRL0 || b != cfd_pkg::TRL1)
                    r.status = cfd_pkg::STATUS_FRAMING;
                else if (rx_crc != crc)
                    r.status = cfd_pkg::STATUS_CRC;
                awaited.push_back(r);
                clear_frame();
            end else if (is_pay) begin
                awaited.push_back(r);
            end
        endfunction

        function void flag(string field, logic [15:0] want_v, logic [15:0] got_v);
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
        endfunction

        // one accepted result transaction against the oldest expectation
        function void check_result(decoded_t got);
            decoded_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing expected, kind %0d status %0d",
                         $time, got.kind, got.status);
                return;
            end
            want = awaited.pop_front();
            if (want.kind == cfd_pkg::KIND_STATUS) verdicts[int'(want.status)]++;
            else payload_seen++;
            if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
            if (got.data_byte !== want.data_byte)
                flag("data_byte", want.data_byte, got.data_byte);
            if (got.byte_index !== want.byte_index)
                flag("byte_index", want.byte_index, got.byte_index);
            if (got.frame_ident !== want.frame_ident)
                flag("frame_ident", want.frame_ident, got.frame_ident);
            if (got.frame_kind_code !== want.frame_kind_code)
                flag("frame_kind_code", want.frame_kind_code, got.frame_kind_code);
            if (got.length_field !== want.length_field)
                flag("length_field", want.length_field, got.length_field);
            if (got.status !== want.status) flag("status", want.status, got.status);
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte       = 8'h00;
    logic        s_end_of_frame  = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b1;
    logic        m_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_byte_index;
    logic [15:0] m_frame_ident;
    logic [7:0]  m_frame_kind_code;
    logic [15:0] m_length_field;
    logic [2:0]  m_status;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_max_payload = 16'd0;

    frame_predictor model = new();
    decoded_t       seen;
    bit             no_idle     = 1'b0;
    int unsigned    cycle_count = 0;
    int unsigned    frames_sent = 0;
    int unsigned    bytes_sent  = 0;
    int unsigned    sink_stall  = 0;
    int unsigned    sink_draw;

    crc_frame_decoder_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .s_end_of_frame    (s_end_of_frame),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data_byte       (m_data_byte),
        .m_byte_index      (m_byte_index),
        .m_frame_ident     (m_frame_ident),
        .m_frame_kind_code (m_frame_kind_code),
        .m_length_field    (m_length_field),
        .m_status          (m_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_max_payload   (cfg_max_payload)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog and transaction monitor, sampling pre-edge values
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", model.awaited.size());
            $display("CHECKS FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.kind            = m_kind;
                seen.data_byte       = m_data_byte;
                seen.byte_index      = m_byte_index;
                seen.frame_ident     = m_frame_ident;
                seen.frame_kind_code = m_frame_kind_code;
                seen.length_field    = m_length_field;
                seen.status          = cfd_pkg::status_t'(m_status);
                model.check_result(seen);
            end
            if (s_valid && s_ready) model.note_byte(s_rx_byte, s_end_of_frame);
        end
    end

    // result side: may stall after each transaction unless no_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b1;
            sink_stall <= 0;
        end else if (m_valid && m_ready) begin
            if (no_idle) begin
                m_ready    <= 1'b1;
                sink_stall <= 0;
            end else begin
                sink_draw   = $urandom_range(0, 3);
                m_ready    <= (sink_draw == 0);
                sink_stall <= sink_draw;
            end
        end else if (sink_stall != 0) begin
            m_ready    <= (sink_stall == 1);
            sink_stall <= sink_stall - 1;
        end
    end

    function automatic octet_q_t random_bytes(int unsigned n);
        octet_q_t q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    // preamble, header, payload, crc over id through payload, trailer
    function automatic octet_q_t build_frame(logic [15:0] ident, logic [7:0] code,
                                             logic [15:0] decl, octet_q_t payload);
        octet_q_t    fr;
        logic [15:0] c;
        int          i;
        fr = {cfd_pkg::PRE0, cfd_pkg::PRE1, ident[7:0], ident[15:8], code,
              decl[7:0], decl[15:8]};
        foreach (payload[k]) fr.push_back(payload[k]);
        c = cfd_pkg::CRC_INIT;
        for (i = cfd_pkg::CRC_START; i < fr.size(); i++)
            c = frame_predictor::modbus_crc(c, fr[i]);
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        fr.push_back(cfd_pkg::TRL0);
        fr.push_back(cfd_pkg::TRL1);
        return fr;
    endfunction

    // input side: optional gap, then hold the transaction until accepted
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rx_byte      <= b;
        s_end_of_frame <= eof;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input octet_q_t fr);
        foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
        frames_sent++;
        bytes_sent += fr.size();
    endtask

    // hold off the sender until every awaited result has been checked
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (model.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_payload(input logic [15:0] v);
        cfg_valid       <= 1'b1;
        cfg_max_payload <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.limit = v;
    endtask

    function automatic fault_e pick_fault();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return FAULT_NONE;
        if (pick < 64) return FAULT_PREAMBLE;
        if (pick < 70) return FAULT_TRAILER;
        if (pick < 76) return FAULT_CRC_BYTE;
        if (pick < 82) return FAULT_BODY_BIT;
        if (pick < 88) return FAULT_TRUNCATE;
        if (pick < 92) return FAULT_EXTRA;
        if (pick < 96) return FAULT_LENGTH;
        return FAULT_NOISE;
    endfunction

    // mostly well-formed frames with random content, the rest damaged or noise
    task automatic send_random_frame();
        octet_q_t    fr;
        int unsigned pick;
        int unsigned plen;
        int unsigned n;
        logic [15:0] decl;
        fault_e      fault;
        pick  = $urandom_range(0, 19);
        plen  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(100, 300) : $urandom_range(1, 24);
        fault = pick_fault();
        decl  = 16'(plen);
        if (fault == FAULT_LENGTH)
            decl = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        fr = build_frame(16'($urandom), 8'($urandom), decl, random_bytes(plen));
        case (fault)
            FAULT_PREAMBLE: fr[$urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
            FAULT_TRAILER:  fr[fr.size() - 2 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
            FAULT_CRC_BYTE: fr[fr.size() - 4 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
            FAULT_BODY_BIT: fr[$urandom_range(2, fr.size() - 5)] ^= 8'h01 << $urandom_range(0, 7);
            FAULT_TRUNCATE: begin
                n = $urandom_range(1, fr.size() - 1);
                while (fr.size() > n) void'(fr.pop_back());
            end
            FAULT_EXTRA: begin
                repeat ($urandom_range(1, 3))
                    fr.insert($urandom_range(7, fr.size() - 1), 8'($urandom));
            end
            FAULT_NOISE: fr = random_bytes($urandom_range(1, 20));
            default: ;
        endcase
        send_frame(fr);
    endtask

    // stimulus
    initial begin
        logic [15:0] limit_v;
        bit          phase_no_idle;
        int unsigned phase_end;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: minimal clean frame, one-byte frame, final flag on a payload byte
        send_frame(build_frame(16'hFFFF, 8'h00, 16'h0000, random_bytes(0)));
        send_frame('{8'h00});
        send_frame('{cfd_pkg::PRE0, cfd_pkg::PRE1, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF});

        // random phases, each under its own payload limit
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                wait_for_results();
                case (ph)
                    1:       limit_v = 16'h0000;
                    2:       limit_v = 16'hFFFF;
                    3:       limit_v = 16'h0001;
                    4:       limit_v = 16'($urandom_range(2, 40));
                    default: limit_v = 16'($urandom);
                endcase
                write_max_payload(limit_v);
            end
            phase_no_idle = ($urandom_range(0, 3) == 0);
            phase_end     = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                no_idle = phase_no_idle || ($urandom_range(0, 5) == 0);
                send_random_frame();
            end
        end
        wait_for_results();

        $display("covered %0d frames, %0d bytes, clean and damaged, under six payload limits",
                 frames_sent, bytes_sent);
        $display("checked %0d payload bytes; verdicts ok %0d short %0d framing %0d size %0d crc %0d",
                 model.payload_seen, model.verdicts[int'(cfd_pkg::STATUS_OK)],
                 model.verdicts[int'(cfd_pkg::STATUS_SHORT)],
                 model.verdicts[int'(cfd_pkg::STATUS_FRAMING)],
                 model.verdicts[int'(cfd_pkg::STATUS_SIZE)],
                 model.verdicts[int'(cfd_pkg::STATUS_CRC)]);
        if (model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
